// ----- hw/rtl/fbrm_pkg.sv -----
package fbrm_pkg;

    localparam int MAX_LEN   = 16;
    localparam int NUM_SLOTS = 2;
    // one spare buffer beyond the slots takes the frame being received
    localparam int NUM_BUFS  = NUM_SLOTS + 1;
    localparam int RAM_DEPTH = NUM_BUFS * MAX_LEN;

    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int IDX_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int BUF_W  = $clog2(NUM_BUFS);
    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int ADDR_W = $clog2(RAM_DEPTH);

    localparam logic [7:0] START_BYTE = 8'h7E;

    localparam logic REQ_RX   = 1'b0;
    localparam logic REQ_POLL = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  rx_byte;
        logic [31:0] now_ms;
    } t_in;

    typedef struct packed {
        logic        msg_valid;
        logic [7:0]  msg_byte;
        logic [4:0]  msg_length;
        logic [31:0] msg_time;
        logic        last;
    } t_out;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN,
        PH_DATA,
        PH_CHECK
    } t_phase;

    typedef enum logic {
        DS_IDLE,
        DS_DRAIN
    } t_dstate;

    typedef struct packed {
        logic len_load;
        logic data_wr;
        logic check;
        logic drain_start;
        logic issue;
    } t_dp_cmd;

    typedef struct packed {
        logic is_start;
        logic len_over;
        logic len_zero;
        logic data_done;
        logic drain_last;
    } t_dp_sts;

    function automatic logic [ADDR_W-1:0] buf_addr(input logic [BUF_W-1:0] b,
                                                   input logic [IDX_W-1:0] idx);
        buf_addr = ADDR_W'(int'(b) * MAX_LEN + int'(idx));
    endfunction

endpackage

// ----- hw/rtl/fbrm_ram.sv -----
module fbrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/fbrm_dp.sv -----
module fbrm_dp
    import fbrm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_in     i_in,
    input  t_dp_cmd i_cmd,
    output t_dp_sts o_sts,
    output t_out    o_out
);

    logic [LEN_W-1:0]  r_decl_len;
    logic [LEN_W-1:0]  r_count;
    logic [7:0]        r_check;
    logic [LEN_W-1:0]  r_slot_len  [NUM_SLOTS];
    logic [31:0]       r_slot_time [NUM_SLOTS];
    logic [BUF_W-1:0]  r_slot_buf  [NUM_SLOTS];
    logic [BUF_W-1:0]  r_scratch;

    // drain context
    logic              r_d_hit;
    logic [LEN_W-1:0]  r_d_len;
    logic [31:0]       r_d_time;
    logic [BUF_W-1:0]  r_d_buf;
    logic [IDX_W-1:0]  r_d_idx;

    // output word side fields; byte comes straight from the RAM read register
    logic              r_o_hit;
    logic [LEN_W-1:0]  r_o_len;
    logic [31:0]       r_o_time;
    logic              r_o_last;

    logic              empty_found;
    logic [SLOT_W-1:0] empty_slot;
    logic              full_found;
    logic [SLOT_W-1:0] full_slot;
    logic              do_store;
    logic [7:0]        rd_data;
    logic              drain_last;
    logic [NUM_BUFS-1:0] buf_used;
    logic              len_ok;

    always_comb begin
        empty_found = 1'b0;
        empty_slot  = '0;
        full_found  = 1'b0;
        full_slot   = '0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            if (!empty_found && r_slot_len[s] == '0) begin
                empty_found = 1'b1;
                empty_slot  = SLOT_W'(s);
            end
            if (!full_found && r_slot_len[s] != '0) begin
                full_found = 1'b1;
                full_slot  = SLOT_W'(s);
            end
        end
    end

    assign do_store = i_cmd.check && (i_in.rx_byte == r_check) &&
                      (r_decl_len != '0) && empty_found;

    assign drain_last = !r_d_hit || ((LEN_W'(r_d_idx) + LEN_W'(1)) == r_d_len);

    assign o_sts.is_start   = (i_in.rx_byte == START_BYTE);
    assign o_sts.len_over   = (i_in.rx_byte > 8'(MAX_LEN));
    assign o_sts.len_zero   = (i_in.rx_byte == 8'h00);
    assign o_sts.data_done  = ((r_count + LEN_W'(1)) >= r_decl_len);
    assign o_sts.drain_last = drain_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decl_len <= '0;
            r_count    <= '0;
            r_check    <= '0;
            r_scratch  <= BUF_W'(NUM_SLOTS);
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r_slot_len[s] <= '0;
                r_slot_buf[s] <= BUF_W'(s);
            end
        end else begin
            if (i_cmd.len_load) begin
                r_decl_len <= o_sts.len_over ? '0 : LEN_W'(i_in.rx_byte);
                r_check    <= i_in.rx_byte;
                r_count    <= '0;
            end
            if (i_cmd.data_wr) begin
                r_count <= r_count + LEN_W'(1);
                r_check <= r_check ^ i_in.rx_byte;
            end
            // the spare buffer already holds the payload: swap it into the slot
            if (do_store) begin
                r_slot_len[empty_slot]  <= r_decl_len;
                r_slot_time[empty_slot] <= i_in.now_ms;
                r_slot_buf[empty_slot]  <= r_scratch;
                r_scratch               <= r_slot_buf[empty_slot];
            end
            if (i_cmd.drain_start && full_found) begin
                r_slot_len[full_slot] <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.drain_start) begin
            r_d_hit  <= full_found;
            r_d_len  <= r_slot_len[full_slot];
            r_d_time <= r_slot_time[full_slot];
            r_d_buf  <= r_slot_buf[full_slot];
            r_d_idx  <= '0;
        end else if (i_cmd.issue) begin
            r_d_idx <= r_d_idx + IDX_W'(1);
        end
        if (i_cmd.issue) begin
            r_o_hit  <= r_d_hit;
            r_o_len  <= r_d_hit ? r_d_len : '0;
            r_o_time <= r_d_hit ? r_d_time : '0;
            r_o_last <= drain_last;
        end
    end

    fbrm_ram #(
        .WIDTH(8),
        .DEPTH(RAM_DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (i_cmd.data_wr),
        .i_wr_addr(buf_addr(r_scratch, r_count[IDX_W-1:0])),
        .i_wr_data(i_in.rx_byte),
        .i_rd_en  (i_cmd.issue && r_d_hit),
        .i_rd_addr(buf_addr(r_d_buf, r_d_idx)),
        .o_rd_data(rd_data)
    );

    assign o_out.msg_valid  = r_o_hit;
    assign o_out.msg_byte   = r_o_hit ? rd_data : 8'h00;
    assign o_out.msg_length = 5'(r_o_len);
    assign o_out.msg_time   = r_o_time;
    assign o_out.last       = r_o_last;

    always_comb begin
        buf_used = '0;
        buf_used[r_scratch] = 1'b1;
        len_ok = 1'b1;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            buf_used[r_slot_buf[s]] = 1'b1;
            if (r_slot_len[s] > LEN_W'(MAX_LEN)) begin
                len_ok = 1'b0;
            end
        end
    end

    // slots and spare always own distinct buffers
    a_buf_perm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        &buf_used)
        else $error("buffer ownership is not a permutation");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        len_ok)
        else $error("stored length above maximum");

    a_no_wr_past_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.data_wr |-> (r_count < r_decl_len))
        else $error("payload write beyond declared length");

endmodule

// ----- hw/rtl/fbrm_ctrl.sv -----
module fbrm_ctrl
    import fbrm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_req_type,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_phase  r_phase, n_phase;
    t_dstate r_dstate, n_dstate;
    logic    r_out_valid, n_out_valid;
    logic    in_fire;
    logic    rx_fire;
    logic    out_fire;

    assign o_in_stall  = (r_dstate != DS_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_fire     = i_in_valid && !o_in_stall;
    assign rx_fire     = in_fire && (i_req_type == REQ_RX);
    assign out_fire    = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_dstate    <= DS_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_dstate    <= n_dstate;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_dstate = r_dstate;
        o_cmd    = '0;

        if (rx_fire) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_sts.is_start) begin
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    o_cmd.len_load = 1'b1;
                    if (i_sts.len_over) begin
                        n_phase = PH_HUNT;
                    end else if (i_sts.len_zero) begin
                        n_phase = PH_CHECK;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    o_cmd.data_wr = 1'b1;
                    if (i_sts.data_done) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    o_cmd.check = 1'b1;
                    n_phase     = PH_HUNT;
                end
                default: n_phase = PH_HUNT;
            endcase
        end

        unique case (r_dstate)
            DS_IDLE: begin
                if (in_fire && i_req_type == REQ_POLL) begin
                    o_cmd.drain_start = 1'b1;
                    n_dstate          = DS_DRAIN;
                end
            end
            DS_DRAIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.issue = 1'b1;
                    if (i_sts.drain_last) begin
                        n_dstate = DS_IDLE;
                    end
                end
            end
            default: n_dstate = DS_IDLE;
        endcase

        n_out_valid = o_cmd.issue ? 1'b1 : (out_fire ? 1'b0 : r_out_valid);
    end

    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("output word dropped while stalled");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.issue && i_sts.drain_last) |=> (r_dstate == DS_IDLE))
        else $error("drain did not end after last word");

    a_issue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.issue |-> (!r_out_valid || !i_out_stall))
        else $error("word issued over a held word");

endmodule

// ----- hw/rtl/framed_byte_receiver_mailbox.sv -----
// Framed byte receiver with a two-slot mailbox.
// Input channel (i_in_valid / o_in_stall, payload i_in): each word is either a
// received serial byte or a poll. Bytes are parsed as 0x7E, length, payload,
// XOR check; a non-empty frame that checks is stored with now_ms in the first
// empty slot, or dropped when both slots are full. A byte word produces no
// result, so bytes may arrive back to back while no poll is draining.
// A poll drains the lowest full slot: one output word per payload byte, last
// set on the final one; with no frame held it gives one word with msg_valid 0.
// Output channel (o_out_valid / i_out_stall, payload o_out).
// A poll loads the drain context; each issue then reads the RAM and fills the
// output register, one word per cycle while not stalled. The input stalls from
// the poll until the last word is issued into the output register; the output
// register frees the input again while the last word still waits.
// A stalled output holds its word and pauses the drain. Payload is kept in a
// single 48-byte RAM with one read and one write port; frames are never copied,
// buffers are swapped between slots and the receive side. Synchronous reset
// empties both slots and returns the parser to hunting for the start byte.
module framed_byte_receiver_mailbox
    import fbrm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    fbrm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in.req_type),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fbrm_dp u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (i_in),
        .i_cmd  (cmd),
        .o_sts  (sts),
        .o_out  (o_out)
    );

endmodule
